### rtl/assert_macros.svh
// Assertion helpers included by the split unit.
// Both sample on the rising edge of clock and are disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### rtl/rfs_pkg.sv
package rfs_pkg;

   // Direction fraction bits (Q1.15) and reflectance fraction bits (Q0.16).
   localparam int DIR_FRAC   = 15;
   localparam int COEFF_FRAC = 16;

   // Refraction index of air in Q2.12.
   localparam logic [13:0] IDX_ONE = 14'd4096;

   // Pipeline depth of the two dividers and of the square root unit.
   localparam int DIV_STAGES  = 8;
   localparam int SQRT_STAGES = 8;

   // Result kinds.
   localparam logic RAY_REFLECT = 1'b0;
   localparam logic RAY_REFRACT = 1'b1;

   typedef struct packed {
      logic               hit_valid;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic        [13:0] refraction_index;
   } req_type;

   typedef struct packed {
      logic               ray_kind;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [15:0] out_dir_x;
      logic signed [15:0] out_dir_y;
      logic signed [15:0] out_dir_z;
      logic        [15:0] reflect_coeff;
      logic               inside_medium;
      logic               last;
   } rsp_type;

endpackage

### rtl/rfs_div.sv
module rfs_div #(
   parameter int NUM_W  = 28,
   parameter int DEN_W  = 14,
   parameter int QUO_W  = 16,
   parameter int STAGES = 8
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);
   // Restoring division, QUO_W / STAGES quotient bits per stage. The caller
   // guarantees that the quotient fits in QUO_W bits, so the numerator bits
   // above the quotient start out as a partial remainder below den.
   localparam int STEPS = QUO_W / STAGES;
   localparam int REM_W = DEN_W + 1;

   logic [REM_W-1:0] rem_ff [STAGES];
   logic [DEN_W-1:0] den_ff [STAGES];
   logic [QUO_W-1:0] low_ff [STAGES];
   logic [QUO_W-1:0] quo_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [REM_W-1:0] rem_src;
      logic [REM_W-1:0] rem_in;
      logic [DEN_W-1:0] den_src;
      logic [QUO_W-1:0] low_src;
      logic [QUO_W-1:0] low_in;
      logic [QUO_W-1:0] quo_src;
      logic [QUO_W-1:0] quo_in;

      if (s == 0) begin : g_first
         assign rem_src = REM_W'(num >> QUO_W);
         assign den_src = den;
         assign low_src = num[QUO_W-1:0];
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign low_src = low_ff[s-1];
         assign quo_src = quo_ff[s-1];
      end

      always_comb begin
         rem_in = rem_src;
         low_in = low_src;
         quo_in = quo_src;
         for (int j = 0; j < STEPS; j++) begin
            rem_in = {rem_in[REM_W-2:0], low_in[QUO_W-1]};
            low_in = {low_in[QUO_W-2:0], 1'b0};
            if (rem_in >= {1'b0, den_src}) begin
               rem_in = rem_in - {1'b0, den_src};
               quo_in = {quo_in[QUO_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_in[QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in;
         den_ff[s] <= den_src;
         low_ff[s] <= low_in;
         quo_ff[s] <= quo_in;
      end
   end

   assign quo = quo_ff[STAGES-1];

endmodule

### rtl/rfs_sqrt.sv
module rfs_sqrt #(
   parameter int VAL_W  = 32,
   parameter int STAGES = 8
) (
   input  logic               clock,
   input  logic [VAL_W-1:0]   val,
   output logic [VAL_W/2-1:0] root
);
   // Digit-by-digit floor square root, one root bit per step.
   localparam int ROOT_W = VAL_W / 2;
   localparam int STEPS  = ROOT_W / STAGES;
   localparam int REM_W  = ROOT_W + 4;

   logic [REM_W-1:0]  rem_ff  [STAGES];
   logic [ROOT_W-1:0] root_ff [STAGES];
   logic [VAL_W-1:0]  val_ff  [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [REM_W-1:0]  rem_src;
      logic [REM_W-1:0]  rem_in;
      logic [REM_W-1:0]  trial;
      logic [ROOT_W-1:0] root_src;
      logic [ROOT_W-1:0] root_in;
      logic [VAL_W-1:0]  val_src;
      logic [VAL_W-1:0]  val_in;

      if (s == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign val_src  = val;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
         assign val_src  = val_ff[s-1];
      end

      always_comb begin
         rem_in  = rem_src;
         root_in = root_src;
         val_in  = val_src;
         trial   = '0;
         for (int j = 0; j < STEPS; j++) begin
            rem_in = {rem_in[REM_W-3:0], val_in[VAL_W-1:VAL_W-2]};
            val_in = {val_in[VAL_W-3:0], 2'b00};
            trial  = REM_W'({root_in, 2'b01});
            if (rem_in >= trial) begin
               rem_in  = rem_in - trial;
               root_in = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
               root_in = {root_in[ROOT_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         root_ff[s] <= root_in;
         val_ff[s]  <= val_in;
      end
   end

   assign root = root_ff[STAGES-1];

endmodule

### rtl/refraction_fresnel_split_unit.sv
// Refraction and Fresnel split unit. Each accepted hit with hit_valid set
// yields a mirror-reflected ray and, unless the ray is totally internally
// reflected, a refracted ray with a Schlick reflectance carried on both
// results; a hit with hit_valid clear is taken and dropped without a result.
// The first result of a hit reaches the result port through the pipeline
// stages and the result register, and a refracted ray follows in the very next
// cycle with last set. The receiver cannot stall: every result is shown for
// exactly one cycle with rsp_valid high and must be taken then. No new hit is
// taken while busy is high: busy is high in the cycle after a hit with
// hit_valid set is accepted, because its two results share the single result port.
// Inside, a 24-stage pipeline computes the geometry, two pipelined dividers
// (relative index and normal-incidence reflectance) and a pipelined square
// root; none of them ever stalls. The surface offset register resets to one
// position LSB, csr_ready is always high, and it may be written only while
// no hit is in flight.
module refraction_fresnel_split_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rfs_pkg::req_type req_data,
   output logic             rsp_valid,
   output rfs_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);
   import rfs_pkg::*;

   `include "assert_macros.svh"

   // Number of pipeline stages ahead of the result register.
   localparam int NST      = 24;
   localparam int DIV_OUT  = 2 + DIV_STAGES;   // stage aligned with divider results
   localparam int SQRT_IN  = 14;               // stage that feeds the square root
   localparam int SQRT_OUT = SQRT_IN + SQRT_STAGES;

   // Everything one hit needs on its way down the pipeline.
   typedef struct {
      logic signed [15:0] d     [3];
      logic signed [15:0] n     [3];
      logic signed [31:0] p     [3];
      logic        [13:0] idx;
      logic signed [31:0] pn    [3];
      logic        [27:0] dsq;
      logic        [29:0] ssq;
      logic signed [33:0] dot;
      logic               leaving;
      logic        [15:0] c;
      logic signed [16:0] nn    [3];
      logic signed [49:0] pr    [3];
      logic signed [33:0] po    [3];
      logic signed [15:0] dir_r [3];
      logic signed [31:0] org_r [3];
      logic signed [31:0] org_t [3];
      logic        [31:0] cc;
      logic        [16:0] u;
      logic        [15:0] s2;
      logic        [16:0] pw;
      logic        [16:0] e;
      logic        [15:0] coeff;
      logic        [19:0] e2;
      logic signed [33:0] ed    [3];
      logic        [17:0] m1;
      logic        [20:0] t;
      logic               tir;
      logic        [15:0] k;
      logic signed [18:0] m;
      logic signed [15:0] dir_t [3];
   } work_type;

   function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
      if (v > 22'sd32767) begin
         return 16'sh7FFF;
      end else if (v < -22'sd32768) begin
         return 16'sh8000;
      end
      return 16'(v);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sh0_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         return 32'sh8000_0000;
      end
      return 32'(v);
   endfunction

   logic [15:0] surface_offset_ff;

   work_type pipe_ff [1:NST];
   work_type pipe_in [1:NST];
   logic [NST:1] vld_ff;
   logic [NST:1] vld_in;

   logic [27:0] eta_num;
   logic [15:0] eta_quo;
   logic [44:0] r0_num;
   logic [15:0] r0_quo;
   logic [31:0] sqrt_val;
   logic [15:0] sqrt_root;

   rsp_type rsp_data_ff;
   logic    rsp_valid_ff;
   rsp_type pend_ff;
   logic    pend_valid_ff;
   rsp_type refl_res;
   rsp_type refr_res;

   // Always taken; the register must be written only while idle, not enforced by the block.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         surface_offset_ff <= 16'd1;
      end else if (csr_valid && csr_ready) begin
         surface_offset_ff <= csr_data;
      end
   end

   // A hit with hit_valid set blocks the next cycle so that its two results can leave in turn.
   assign busy = vld_ff[1];

   // Air to material index ratio and normal-incidence reflectance.
   assign eta_num = (28'(IDX_ONE) << DIR_FRAC) + 28'(pipe_ff[2].idx >> 1);
   assign r0_num  = {pipe_ff[2].dsq, 16'd0} + 45'(pipe_ff[2].ssq >> 1);

   rfs_div #(
      .NUM_W  (28),
      .DEN_W  (14),
      .QUO_W  (16),
      .STAGES (DIV_STAGES)
   ) u_div_eta (
      .clock (clock),
      .num   (eta_num),
      .den   (pipe_ff[2].idx),
      .quo   (eta_quo)
   );

   rfs_div #(
      .NUM_W  (45),
      .DEN_W  (30),
      .QUO_W  (COEFF_FRAC),
      .STAGES (DIV_STAGES)
   ) u_div_r0 (
      .clock (clock),
      .num   (r0_num),
      .den   (pipe_ff[2].ssq),
      .quo   (r0_quo)
   );

   assign sqrt_val = 32'(pipe_ff[SQRT_IN].k) << DIR_FRAC;

   rfs_sqrt #(
      .VAL_W  (32),
      .STAGES (SQRT_STAGES)
   ) u_sqrt (
      .clock (clock),
      .val   (sqrt_val),
      .root  (sqrt_root)
   );

   always_comb begin
      logic signed [34:0] cr;
      logic signed [50:0] rr;
      logic signed [33:0] off;
      logic        [33:0] cp;
      logic        [17:0] csum;
      logic signed [36:0] acc;

      cr   = '0;
      rr   = '0;
      off  = '0;
      cp   = '0;
      csum = '0;
      acc  = '0;

      for (int s = 2; s <= NST; s++) begin
         pipe_in[s] = pipe_ff[s-1];
         vld_in[s]  = vld_ff[s-1];
      end

      // Stage 1: capture the hit; an index below air is raised to air.
      pipe_in[1]      = '{default: '0};
      vld_in[1]       = start && !busy && req_data.hit_valid;
      pipe_in[1].d[0] = req_data.dir_x;
      pipe_in[1].d[1] = req_data.dir_y;
      pipe_in[1].d[2] = req_data.dir_z;
      pipe_in[1].n[0] = req_data.normal_x;
      pipe_in[1].n[1] = req_data.normal_y;
      pipe_in[1].n[2] = req_data.normal_z;
      pipe_in[1].p[0] = req_data.point_x;
      pipe_in[1].p[1] = req_data.point_y;
      pipe_in[1].p[2] = req_data.point_z;
      pipe_in[1].idx  = (req_data.refraction_index < IDX_ONE) ? IDX_ONE
                                                                : req_data.refraction_index;

      // Stage 2: dot product terms and the squares for the reflectance.
      for (int i = 0; i < 3; i++) begin
         pipe_in[2].pn[i] = 32'(pipe_ff[1].d[i]) * 32'(pipe_ff[1].n[i]);
      end
      pipe_in[2].dsq = 28'(pipe_ff[1].idx - IDX_ONE) * 28'(pipe_ff[1].idx - IDX_ONE);
      pipe_in[2].ssq = 30'(15'(pipe_ff[1].idx) + 15'(IDX_ONE))
                     * 30'(15'(pipe_ff[1].idx) + 15'(IDX_ONE));

      // Stage 3: full-precision dot product; a positive one means leaving.
      pipe_in[3].dot = 34'(pipe_ff[2].pn[0]) + 34'(pipe_ff[2].pn[1])
                     + 34'(pipe_ff[2].pn[2]);
      pipe_in[3].leaving = (34'(pipe_ff[2].pn[0]) + 34'(pipe_ff[2].pn[1])
                            + 34'(pipe_ff[2].pn[2])) > 34'sd0;

      // Stage 4: cosine, flipped normal, reflection and offset products.
      cr = (pipe_ff[3].leaving ? 35'(pipe_ff[3].dot) : -35'(pipe_ff[3].dot))
           + 35'sd16384;
      cr = cr >>> DIR_FRAC;
      pipe_in[4].c = (cr > 35'sd32768) ? 16'd32768 : 16'(cr);
      for (int i = 0; i < 3; i++) begin
         pipe_in[4].nn[i] = pipe_ff[3].leaving ? -17'(pipe_ff[3].n[i])
                                               : 17'(pipe_ff[3].n[i]);
         pipe_in[4].pr[i] = 50'(pipe_ff[3].dot) * 50'(pipe_ff[3].n[i]);
         pipe_in[4].po[i] = 34'(pipe_in[4].nn[i])
                          * 34'(signed'({1'b0, surface_offset_ff}));
      end

      // Stage 5: reflected direction, both origins, cosine squared.
      for (int i = 0; i < 3; i++) begin
         rr  = (51'(pipe_ff[4].pr[i]) + (51'sd1 <<< (2 * DIR_FRAC - 2)))
               >>> (2 * DIR_FRAC - 1);
         pipe_in[5].dir_r[i] = sat16(22'(pipe_ff[4].d[i]) - 22'(rr));
         off = (pipe_ff[4].po[i] + 34'sd16384) >>> DIR_FRAC;
         pipe_in[5].org_r[i] = sat32(34'(pipe_ff[4].p[i]) + off);
         pipe_in[5].org_t[i] = sat32(34'(pipe_ff[4].p[i]) - off);
      end
      pipe_in[5].cc = 32'(pipe_ff[4].c) * 32'(pipe_ff[4].c);
      pipe_in[5].u  = {16'(16'd32768 - pipe_ff[4].c), 1'b0};

      // Stage 6: sine squared and the second power of (1 - c).
      pipe_in[6].s2 = 16'((32'h4000_0000 - pipe_ff[5].cc + 32'd16384) >> DIR_FRAC);
      pipe_in[6].pw = 17'((34'(pipe_ff[5].u) * 34'(pipe_ff[5].u) + 34'd32768) >> COEFF_FRAC);

      // Stages 7 to 9: remaining powers up to the fifth.
      for (int s = 7; s <= 9; s++) begin
         pipe_in[s].pw = 17'((34'(pipe_ff[s-1].pw) * 34'(pipe_ff[s-1].u) + 34'd32768)
                             >> COEFF_FRAC);
      end

      // Stage after the dividers: select eta and form the reflectance.
      pipe_in[DIV_OUT+1].e = pipe_ff[DIV_OUT].leaving ? {pipe_ff[DIV_OUT].idx, 3'b000}
                                                      : {1'b0, eta_quo};
      cp   = 34'(17'd65536 - {1'b0, r0_quo}) * 34'(pipe_ff[DIV_OUT].pw);
      csum = 18'(r0_quo) + 18'((cp + 34'd32768) >> COEFF_FRAC);
      pipe_in[DIV_OUT+1].coeff = (csum > 18'd65535) ? 16'hFFFF : 16'(csum);

      // Stage 12: eta squared, eta times direction, eta times cosine.
      pipe_in[12].e2 = 20'((34'(pipe_ff[11].e) * 34'(pipe_ff[11].e) + 34'd16384) >> DIR_FRAC);
      for (int i = 0; i < 3; i++) begin
         pipe_in[12].ed[i] = 34'(signed'({1'b0, pipe_ff[11].e})) * 34'(pipe_ff[11].d[i]);
      end
      pipe_in[12].m1 = 18'((33'(pipe_ff[11].e) * 33'(pipe_ff[11].c) + 33'd16384) >> DIR_FRAC);

      // Stage 13: eta squared times sine squared.
      pipe_in[13].t = 21'((36'(pipe_ff[12].e2) * 36'(pipe_ff[12].s2) + 36'd16384) >> DIR_FRAC);

      // Stage 14: total internal reflection test and the root argument.
      pipe_in[14].tir = pipe_ff[13].t > 21'd32768;
      pipe_in[14].k   = pipe_in[14].tir ? 16'd0 : 16'(21'd32768 - pipe_ff[13].t);

      // Stage after the square root: normal weight of the refracted ray.
      pipe_in[SQRT_OUT+1].m = 19'(signed'({1'b0, pipe_ff[SQRT_OUT].m1}))
                            - 19'(signed'({3'b000, sqrt_root}));

      // Stage 24: refracted direction.
      for (int i = 0; i < 3; i++) begin
         acc = 37'(pipe_ff[23].ed[i]) + 37'(pipe_ff[23].m) * 37'(pipe_ff[23].nn[i]);
         acc = (acc + 37'sd16384) >>> DIR_FRAC;
         pipe_in[24].dir_t[i] = sat16(22'(acc));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_ff <= pipe_in;
   end

   // Both results of the hit at the end of the pipeline.
   always_comb begin
      refl_res.ray_kind      = RAY_REFLECT;
      refl_res.origin_x      = pipe_ff[NST].org_r[0];
      refl_res.origin_y      = pipe_ff[NST].org_r[1];
      refl_res.origin_z      = pipe_ff[NST].org_r[2];
      refl_res.out_dir_x     = pipe_ff[NST].dir_r[0];
      refl_res.out_dir_y     = pipe_ff[NST].dir_r[1];
      refl_res.out_dir_z     = pipe_ff[NST].dir_r[2];
      refl_res.reflect_coeff = pipe_ff[NST].tir ? 16'd0 : pipe_ff[NST].coeff;
      refl_res.inside_medium = pipe_ff[NST].leaving;
      refl_res.last          = pipe_ff[NST].tir;

      refr_res.ray_kind      = RAY_REFRACT;
      refr_res.origin_x      = pipe_ff[NST].org_t[0];
      refr_res.origin_y      = pipe_ff[NST].org_t[1];
      refr_res.origin_z      = pipe_ff[NST].org_t[2];
      refr_res.out_dir_x     = pipe_ff[NST].dir_t[0];
      refr_res.out_dir_y     = pipe_ff[NST].dir_t[1];
      refr_res.out_dir_z     = pipe_ff[NST].dir_t[2];
      refr_res.reflect_coeff = pipe_ff[NST].coeff;
      refr_res.inside_medium = pipe_ff[NST].leaving;
      refr_res.last          = 1'b1;
   end

   // The reflected ray leaves first; the refracted one waits in the pending
   // register. Hits never arrive here back to back, as busy holds them apart.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (vld_ff[NST]) begin
            rsp_valid_ff  <= 1'b1;
            rsp_data_ff   <= refl_res;
            pend_valid_ff <= !pipe_ff[NST].tir;
            pend_ff       <= refr_res;
         end else if (pend_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            rsp_data_ff   <= pend_ff;
            pend_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_NXT(a_busy_after_hit, start && !busy && req_data.hit_valid, busy)
   `ASSERT_IMP(a_no_result_overlap, vld_ff[NST], !pend_valid_ff)
   `ASSERT_NXT(a_refract_follows, rsp_valid_ff && !rsp_data_ff.last, rsp_valid_ff && rsp_data_ff.ray_kind == RAY_REFRACT && rsp_data_ff.last)
   `ASSERT_IMP(a_tir_no_coeff, rsp_valid_ff && rsp_data_ff.ray_kind == RAY_REFLECT && rsp_data_ff.last, rsp_data_ff.reflect_coeff == 16'd0)

endmodule

### test/tb_refraction_fresnel_split_unit.sv
`timescale 1ns / 1ps

// This bench drives ray hits into the refraction and Fresnel split unit, predicts
// the reflected and refracted rays for each hit, and checks every result item
// against the oldest prediction, field by field.
module tb_refraction_fresnel_split_unit;
   import rfs_pkg::*;

   // The settle time before a register write and at the end is kept well above
   // the time from an accepted hit to its first result.
   localparam int SETTLE_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   // The bench keeps its own copy of the surface offset register.
   logic [15:0] offset_lsbs = 16'd1;
   rsp_type     ray_queue[$];
   int          error_count = 0;

   refraction_fresnel_split_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Shifts right with rounding half up, that is floor of value plus half.
   function automatic longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic logic signed [31:0] sat_org(input longint v);
      return 32'(clamp(v, -64'sd2147483648, 64'sd2147483647));
   endfunction

   function automatic logic signed [15:0] sat_dir(input longint v);
      return 16'(clamp(v, -32768, 32767));
   endfunction

   function automatic longint int_root(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   // Computes the rays that one hit yields and appends them to the queue.
   task automatic predict_rays(input req_type h);
      longint d[3], n[3], nf[3], p[3], off[3], org[3], dir[3];
      longint dot, c, s2, k, m, r0, u, pw, coeff, idx, a, b, e, e2, t, one, sum2;
      bit leaving;
      rsp_type r;
      one = 64'sd1 <<< DIR_FRAC;
      if (!h.hit_valid) return;
      d = '{h.dir_x, h.dir_y, h.dir_z};
      n = '{h.normal_x, h.normal_y, h.normal_z};
      p = '{h.point_x, h.point_y, h.point_z};
      dot = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
      idx = h.refraction_index;
      if (idx < IDX_ONE) idx = IDX_ONE;
      // A positive dot product means the ray is leaving the medium.
      leaving = dot > 0;
      for (int i = 0; i < 3; i++) nf[i] = leaving ? -n[i] : n[i];
      a = leaving ? idx : IDX_ONE;
      b = leaving ? IDX_ONE : idx;
      for (int i = 0; i < 3; i++) begin
         off[i] = round_shift(nf[i] * longint'(offset_lsbs), DIR_FRAC);
         org[i] = p[i] + off[i];
         dir[i] = d[i] - round_shift(2 * dot * n[i], 2 * DIR_FRAC);
      end
      c = round_shift(leaving ? dot : -dot, DIR_FRAC);
      if (c > one) c = one;
      s2 = round_shift((64'sd1 <<< (2 * DIR_FRAC)) - c * c, DIR_FRAC);
      e = ((a <<< DIR_FRAC) + (b >>> 1)) / b;
      e2 = (e * e + (64'sd1 <<< (DIR_FRAC - 1))) >>> DIR_FRAC;
      t = (e2 * s2 + (64'sd1 <<< (DIR_FRAC - 1))) >>> DIR_FRAC;
      r.inside_medium = leaving;
      r.ray_kind = RAY_REFLECT;
      r.origin_x = sat_org(org[0]);
      r.origin_y = sat_org(org[1]);
      r.origin_z = sat_org(org[2]);
      r.out_dir_x = sat_dir(dir[0]);
      r.out_dir_y = sat_dir(dir[1]);
      r.out_dir_z = sat_dir(dir[2]);
      if (t > one) begin
         // Total internal reflection gives the reflected ray alone.
         r.reflect_coeff = '0;
         r.last = 1'b1;
         ray_queue.push_back(r);
         return;
      end
      k = one - t;
      r0 = a > b ? a - b : b - a;
      sum2 = (a + b) * (a + b);
      r0 = ((r0 * r0 <<< 16) + (sum2 >>> 1)) / sum2;
      u = (one - c) <<< (COEFF_FRAC - DIR_FRAC);
      pw = u;
      for (int i = 0; i < 4; i++) pw = round_shift(pw * u, COEFF_FRAC);
      coeff = r0 + round_shift((65536 - r0) * pw, COEFF_FRAC);
      if (coeff > 65535) coeff = 65535;
      r.reflect_coeff = 16'(coeff);
      r.last = 1'b0;
      ray_queue.push_back(r);
      m = round_shift(e * c, DIR_FRAC) - int_root(k <<< DIR_FRAC);
      for (int i = 0; i < 3; i++) begin
         org[i] = p[i] - off[i];
         dir[i] = round_shift(e * d[i] + m * nf[i], DIR_FRAC);
      end
      r.ray_kind = RAY_REFRACT;
      r.last = 1'b1;
      r.origin_x = sat_org(org[0]);
      r.origin_y = sat_org(org[1]);
      r.origin_z = sat_org(org[2]);
      r.out_dir_x = sat_dir(dir[0]);
      r.out_dir_y = sat_dir(dir[1]);
      r.out_dir_z = sat_dir(dir[2]);
      ray_queue.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // Every result item is compared with the oldest prediction.
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid) begin
         if (ray_queue.size() == 0) begin
            report_mismatch("unexpected result, kind", rsp_data.ray_kind, -1);
         end else begin
            w = ray_queue.pop_front();
            if (rsp_data.ray_kind !== w.ray_kind)
               report_mismatch("ray_kind", rsp_data.ray_kind, w.ray_kind);
            if (rsp_data.origin_x !== w.origin_x)
               report_mismatch("origin_x", rsp_data.origin_x, w.origin_x);
            if (rsp_data.origin_y !== w.origin_y)
               report_mismatch("origin_y", rsp_data.origin_y, w.origin_y);
            if (rsp_data.origin_z !== w.origin_z)
               report_mismatch("origin_z", rsp_data.origin_z, w.origin_z);
            if (rsp_data.out_dir_x !== w.out_dir_x)
               report_mismatch("out_dir_x", rsp_data.out_dir_x, w.out_dir_x);
            if (rsp_data.out_dir_y !== w.out_dir_y)
               report_mismatch("out_dir_y", rsp_data.out_dir_y, w.out_dir_y);
            if (rsp_data.out_dir_z !== w.out_dir_z)
               report_mismatch("out_dir_z", rsp_data.out_dir_z, w.out_dir_z);
            if (rsp_data.reflect_coeff !== w.reflect_coeff)
               report_mismatch("reflect_coeff", rsp_data.reflect_coeff, w.reflect_coeff);
            if (rsp_data.inside_medium !== w.inside_medium)
               report_mismatch("inside_medium", rsp_data.inside_medium, w.inside_medium);
            if (rsp_data.last !== w.last)
               report_mismatch("last", rsp_data.last, w.last);
         end
      end
   end

   // Mostly short gaps, now and then a long one, and often none at all.
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 50) return 0;
      if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offers one hit and holds it until the edge that accepts it. With keep
   // set the caller offers the next hit at this same falling edge, so start
   // stays high.
   task automatic send_hit(input req_type h, input bit keep);
      start <= 1'b1;
      req_data <= h;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_rays(h);
      @(negedge clock);
      if (!keep) start <= 1'b0;
   endtask

   // Waits for every predicted ray, then lets dropped hits drain as well.
   task automatic drain();
      while (ray_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_offset(input logic [15:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      offset_lsbs = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // A hit on a random, usually unit-ish vector pair, with any index the field allows.
   function automatic req_type random_hit();
      req_type h;
      int axis;
      h.hit_valid = $urandom_range(0, 19) != 0;
      h.dir_x = 16'($urandom); h.dir_y = 16'($urandom); h.dir_z = 16'($urandom);
      h.normal_x = 16'($urandom); h.normal_y = 16'($urandom); h.normal_z = 16'($urandom);
      if ($urandom_range(0, 3) != 0) begin
         // Scale to about unit length so the cosine stays meaningful.
         h.dir_x = h.dir_x >>> 1; h.dir_y = h.dir_y >>> 1; h.dir_z = h.dir_z >>> 1;
         axis = $urandom_range(0, 2);
         h.normal_x = axis == 0 ? 16'sd32767 : h.normal_x >>> 3;
         h.normal_y = axis == 1 ? -16'sd32768 : h.normal_y >>> 3;
         h.normal_z = axis == 2 ? 16'sd23170 : h.normal_z >>> 3;
      end
      h.point_x = $urandom; h.point_y = $urandom; h.point_z = $urandom;
      h.refraction_index = 14'($urandom_range(0, 99) < 80 ? $urandom_range(4096, 16383)
                                                          : $urandom);
      return h;
   endfunction

   function automatic req_type make_hit(input int dx, dy, dz, nx, ny, nz,
                                        input int px, input int idx);
      req_type h;
      h.hit_valid = 1'b1;
      h.dir_x = 16'(dx); h.dir_y = 16'(dy); h.dir_z = 16'(dz);
      h.normal_x = 16'(nx); h.normal_y = 16'(ny); h.normal_z = 16'(nz);
      h.point_x = px; h.point_y = -px; h.point_z = px ^ 32'h5555_AAAA;
      h.refraction_index = 14'(idx);
      return h;
   endfunction

   // Covers entering, leaving, grazing, normal incidence, total internal
   // reflection, the index floor, a missed hit and origin saturation.
   task automatic test_directed();
      req_type hits[$];
      hits.push_back(make_hit(0, 0, -32768, 0, 0, 32767, 0, 6144));
      hits.push_back(make_hit(23170, 0, -23170, 0, 0, 32767, 65536, 16383));
      hits.push_back(make_hit(23170, 0, 23170, 0, 0, 32767, -65536, 6144));
      hits.push_back(make_hit(31000, 0, 10000, 0, 0, 32767, 12345, 16383));
      hits.push_back(make_hit(32767, 0, 0, 0, 0, 32767, 7, 5000));
      hits.push_back(make_hit(0, 32767, 0, 0, -32768, 0, 32'h7FFF_FFFF, 100));
      hits.push_back(make_hit(-32768, -32768, -32768, 32767, 32767, 32767,
                              32'h8000_0000, 4096));
      hits.push_back(make_hit(32767, 32767, 32767, -32768, -32768, -32768, -1, 0));
      hits.push_back(make_hit(-32768, 0, 0, 32767, 0, 0, 32'h7FFF_0000, 14'h3FFF));
      hits.push_back(make_hit(100, -200, -32000, 0, 0, 32767, 1, 4097));
      hits.push_back(make_hit(0, 0, -32768, 0, 0, 32767, 0, 6144));
      hits[hits.size() - 1].hit_valid = 1'b0;
      foreach (hits[i]) send_hit(hits[i], i + 1 < hits.size());
   endtask

   task automatic test_offset_extremes();
      write_offset(16'hFFFF);
      send_hit(make_hit(0, 0, -32768, 0, 0, 32767, 32'h7FFF_FFF0, 6144), 1'b1);
      send_hit(make_hit(0, 0, 32767, 0, 0, 32767, 32'h8000_0010, 6144), 1'b0);
      write_offset(16'd0);
      send_hit(make_hit(23170, 0, -23170, 0, 0, 32767, 5, 8192), 1'b0);
   endtask

   task automatic test_random(input int count);
      int gap;
      bit pause;
      gap = pick_gap();
      for (int i = 0; i < count; i++) begin
         repeat (gap) @(negedge clock);
         gap = pick_gap();
         // The sender waits for the block to empty now and then.
         pause = i % 97 == 50;
         send_hit(random_hit(), gap == 0 && !pause && i + 1 < count);
         if (pause) begin
            @(negedge clock);
            while (ray_queue.size() != 0) @(negedge clock);
         end
      end
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_offset_extremes();
      write_offset(16'd1);
      test_random(200);
      write_offset(16'd300);
      test_random(200);
      write_offset(16'($urandom));
      test_random(200);
      drain();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/rfs_pkg.sv
rtl/rfs_div.sv
rtl/rfs_sqrt.sv
rtl/refraction_fresnel_split_unit.sv
test/tb_refraction_fresnel_split_unit.sv
